[design/mrs_pkg.sv]
// shared constants, types and helper functions of the modbus rtu slave engine
package mrs_pkg;

   localparam int FRAME_MAX     = 20;
   localparam int TABLE_ENTRIES = 24;
   localparam int NV_BYTES      = 128;
   localparam int MAX_READ_REGS = 29;

   localparam int COUNT_W   = $clog2(FRAME_MAX + 1);
   localparam int HDR_BYTES = 6;
   localparam int HDR_W     = $clog2(HDR_BYTES);
   localparam int TABLE_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NV_W      = (NV_BYTES > 1) ? $clog2(NV_BYTES) : 1;
   localparam int Q_W       = $clog2(MAX_READ_REGS + 1);
   localparam int STEP_W    = $clog2(2 * MAX_READ_REGS + 5);

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  EXC_FLAG = 8'h80;
   localparam logic [7:0]  DEV_MASK = 8'h3F;
   localparam logic [7:0]  COIL_ON  = 8'hFF;

   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_GAP  = 2'd1;
   localparam logic [1:0] CMD_END  = 2'd2;

   localparam logic REG_UNIT_ID = 1'b0;
   localparam logic REG_RELAYS  = 1'b1;

   localparam logic [7:0] FN_READ_BIT  = 8'h01;
   localparam logic [7:0] FN_READ_HOLD = 8'h03;
   localparam logic [7:0] FN_READ_IN   = 8'h04;
   localparam logic [7:0] FN_WRITE_BIT = 8'h05;
   localparam logic [7:0] FN_WRITE_REG = 8'h06;
   localparam logic [7:0] FN_MSG_COUNT = 8'h0B;
   localparam logic [7:0] FN_REPORT_ID = 8'h11;

   localparam logic [7:0] EXC_CODE    = 8'h01;
   localparam logic [7:0] ID_LENGTH   = 8'h03;
   localparam logic [7:0] ID_DEVICE   = 8'h23;
   localparam logic [7:0] ID_VERSION  = 8'h02;
   localparam logic [7:0] ID_RUNNING  = 8'hFF;

   localparam logic [7:0] ADDR_UNIT  = 8'd0;
   localparam logic [7:0] ADDR_RELAY = 8'd8;
   localparam logic [7:0] ADDR_DEV1  = 8'd30;
   localparam logic [7:0] ADDR_DEV2  = 8'd31;
   localparam logic [7:0] ADDR_PLAN  = 8'd32;
   localparam logic [7:0] ADDR_BLOCK = 8'd64;
   localparam logic [7:0] ADDR_NV    = 8'd96;
   localparam logic [7:0] ADDR_END   = 8'd224;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RXCRC = 8'b0000_0010,
      ST_EXEC  = 8'b0000_0100,
      ST_READ  = 8'b0000_1000,
      ST_WRITE = 8'b0001_0000,
      ST_EMIT  = 8'b0010_0000,
      ST_TXCRC = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      CL_BAD, CL_F1, CL_F34, CL_F5, CL_F6, CL_F11, CL_F17
   } class_type;

   typedef enum logic [3:0] {
      E_CONST, E_UNIT, E_MAP, E_BIT, E_FB2, E_FB3, E_FB5,
      E_MCH, E_MCL, E_QX2, E_CRCH, E_CRCL
   } emit_sel_type;

   typedef struct packed {
      logic             rx_store;
      logic             gap_set;
      logic             clear_rx;
      logic             exec_start;
      logic             msg_inc;
      logic             rd_en;
      logic             rd_seq;
      logic [Q_W-1:0]   rd_offset;
      logic             wr_en;
      logic             wr_rmw;
      logic             emit_en;
      logic             emit_crc;
      emit_sel_type     emit_sel;
      logic [7:0]       emit_const;
      logic             emit_last;
      logic             crc_shift;
   } mrs_ctrl_type;

   typedef struct packed {
      logic             rx_crc_go;
      logic             frame_ok;
      logic [7:0]       fn;
      logic             len8;
      logic             len4;
      logic             q_ok;
      logic [Q_W-1:0]   q;
      logic             out_free;
   } mrs_status_type;

   function automatic logic [15:0] crc_step(input logic [15:0] c);
      crc_step = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
   endfunction

endpackage

[design/mrs_if.sv]
// request, response and register write channels of the modbus rtu slave engine
interface mrs_req_if import mrs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic       line_error;
   modport source(output valid, cmd, rx_byte, line_error, input ready);
   modport sink(input valid, cmd, rx_byte, line_error, output ready);
endinterface

interface mrs_rsp_if import mrs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;
   logic [1:0] relay_state;
   modport source(output valid, tx_byte, last_byte, relay_state, input ready);
   modport sink(input valid, tx_byte, last_byte, relay_state, output ready);
endinterface

interface mrs_csr_if import mrs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

[design/mrs_ctrl.sv]
// controller state machine: request handling, frame execution and response sequencing
module mrs_ctrl import mrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_cmd,
   output logic           req_ready,
   input  mrs_status_type status,
   output mrs_ctrl_type   ctrl
);

   typedef struct packed {
      emit_sel_type sel;
      logic [7:0]   value;
   } emit_type;

   state_type          state_ff, state_in;
   class_type          class_ff, class_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [2:0]         bit_cnt_ff, bit_cnt_in;
   emit_type           cur, nxt;
   logic [STEP_W-1:0]  step_j;
   logic               known;

   function automatic emit_type emit_plan(input class_type cl, input logic [STEP_W-1:0] s,
                                          input logic [Q_W-1:0] q, input logic [7:0] fn);
      logic [STEP_W-1:0] n;
      logic [STEP_W-1:0] j;
      emit_type          e;
      e.sel   = E_CONST;
      e.value = 8'h00;
      j = s - STEP_W'(3);
      case (cl)
         CL_F1:   n = STEP_W'(3);
         CL_F34:  n = STEP_W'({q, 1'b0}) + STEP_W'(2);
         CL_F11:  n = STEP_W'(3);
         CL_BAD:  n = STEP_W'(2);
         default: n = STEP_W'(5);
      endcase
      if (s == '0) begin
         e.sel = E_UNIT;
      end else if (s == n + STEP_W'(1)) begin
         e.sel = E_CRCH;
      end else if (s > n) begin
         e.sel = E_CRCL;
      end else begin
         case (cl)
            CL_BAD: e.value = (s == STEP_W'(1)) ? (fn | EXC_FLAG) : EXC_CODE;
            CL_F1: begin
               if (s == STEP_W'(3)) e.sel = E_BIT;
               else e.value = 8'h01;
            end
            CL_F34: begin
               if (s == STEP_W'(1)) e.value = fn;
               else if (s == STEP_W'(2)) e.sel = E_QX2;
               else if (j[0]) e.sel = E_MAP;
            end
            CL_F5: begin
               case (s)
                  STEP_W'(1): e.value = FN_WRITE_BIT;
                  STEP_W'(2): e.sel = E_FB2;
                  STEP_W'(3): e.sel = E_FB3;
                  STEP_W'(5): e.value = 8'h01;
                  default:    e.value = 8'h00;
               endcase
            end
            CL_F6: begin
               case (s)
                  STEP_W'(1): e.value = FN_WRITE_REG;
                  STEP_W'(3): e.sel = E_FB3;
                  STEP_W'(5): e.sel = E_FB5;
                  default:    e.value = 8'h00;
               endcase
            end
            CL_F11: begin
               case (s)
                  STEP_W'(1): e.value = FN_MSG_COUNT;
                  STEP_W'(2): e.sel = E_MCH;
                  default:    e.sel = E_MCL;
               endcase
            end
            default: begin
               case (s)
                  STEP_W'(1): e.value = FN_REPORT_ID;
                  STEP_W'(2): e.value = ID_LENGTH;
                  STEP_W'(3): e.value = ID_DEVICE;
                  STEP_W'(4): e.value = ID_VERSION;
                  default:    e.value = ID_RUNNING;
               endcase
            end
         endcase
      end
      emit_plan = e;
   endfunction

   always_comb begin
      state_in   = state_ff;
      class_in   = class_ff;
      step_in    = step_ff;
      bit_cnt_in = bit_cnt_ff;
      req_ready  = 1'b0;
      known      = 1'b1;
      ctrl       = '0;
      cur        = emit_plan(class_ff, step_ff, status.q, status.fn);
      nxt        = emit_plan(class_ff, step_ff + STEP_W'(1), status.q, status.fn);
      step_j     = step_ff - STEP_W'(3);
      ctrl.emit_sel   = cur.sel;
      ctrl.emit_const = cur.value;
      ctrl.rd_offset  = step_j[Q_W:1];
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_BYTE: begin
                     ctrl.rx_store = 1'b1;
                     if (status.rx_crc_go) begin
                        bit_cnt_in = '0;
                        state_in   = ST_RXCRC;
                     end
                  end
                  CMD_GAP: ctrl.gap_set = 1'b1;
                  CMD_END: begin
                     if (status.frame_ok) begin
                        ctrl.exec_start = 1'b1;
                        state_in        = ST_EXEC;
                     end else begin
                        ctrl.clear_rx = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RXCRC: begin
            ctrl.crc_shift = 1'b1;
            bit_cnt_in     = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd6) state_in = ST_IDLE;
         end
         ST_EXEC: begin
            unique case (status.fn)
               FN_READ_BIT:  class_in = status.len8 ? CL_F1 : CL_BAD;
               FN_READ_HOLD, FN_READ_IN:
                  class_in = (status.len8 && status.q_ok) ? CL_F34 : CL_BAD;
               FN_WRITE_BIT: class_in = status.len8 ? CL_F5 : CL_BAD;
               FN_WRITE_REG: class_in = status.len8 ? CL_F6 : CL_BAD;
               FN_MSG_COUNT: class_in = status.len4 ? CL_F11 : CL_BAD;
               FN_REPORT_ID: class_in = status.len4 ? CL_F17 : CL_BAD;
               default: begin
                  class_in = CL_BAD;
                  known    = 1'b0;
               end
            endcase
            ctrl.msg_inc = known;
            step_in      = '0;
            if (class_in == CL_F1 || class_in == CL_F5) state_in = ST_READ;
            else if (class_in == CL_F6) state_in = ST_WRITE;
            else state_in = ST_EMIT;
         end
         ST_READ: begin
            ctrl.rd_en  = 1'b1;
            ctrl.rd_seq = (class_ff == CL_F34);
            state_in    = (class_ff == CL_F5) ? ST_WRITE : ST_EMIT;
         end
         ST_WRITE: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_rmw = (class_ff == CL_F5);
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               ctrl.emit_en   = 1'b1;
               ctrl.emit_last = (cur.sel == E_CRCL);
               if (cur.sel == E_CRCL) begin
                  state_in = ST_DONE;
               end else if (cur.sel == E_CRCH) begin
                  step_in = step_ff + STEP_W'(1);
               end else begin
                  ctrl.emit_crc = 1'b1;
                  bit_cnt_in    = '0;
                  state_in      = ST_TXCRC;
               end
            end
         end
         ST_TXCRC: begin
            ctrl.crc_shift = 1'b1;
            bit_cnt_in     = bit_cnt_ff + 3'd1;
            if (bit_cnt_ff == 3'd6) begin
               step_in  = step_ff + STEP_W'(1);
               state_in = (nxt.sel == E_MAP) ? ST_READ : ST_EMIT;
            end
         end
         ST_DONE: begin
            ctrl.clear_rx = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         class_ff   <= CL_BAD;
         step_ff    <= '0;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         class_ff   <= class_in;
         step_ff    <= step_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

endmodule

[design/mrs_dp.sv]
// datapath: receive buffer, serial crc, register map, store and response register
module mrs_dp import mrs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     rx_byte,
   input  logic           line_error,
   input  logic           csr_write,
   input  logic           csr_index,
   input  logic [7:0]     csr_wdata,
   input  mrs_ctrl_type   ctrl,
   output mrs_status_type status,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output logic [7:0]     tx_byte,
   output logic           last_byte,
   output logic [1:0]     relay_state
);

   logic [7:0]         hdr_ff [HDR_BYTES];
   logic [7:0]         hdr_in [HDR_BYTES];
   logic [7:0]         b1_ff, b1_in, b2_ff, b2_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               gap_ff, gap_in, aborted_ff, aborted_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         unit_ff, unit_in;
   logic [1:0]         relays_ff, relays_in;
   logic [7:0]         dev1_ff, dev1_in, dev2_ff, dev2_in;
   logic [7:0]         plan_ff [TABLE_ENTRIES];
   logic [7:0]         plan_in [TABLE_ENTRIES];
   logic [7:0]         block_ff [TABLE_ENTRIES];
   logic [7:0]         block_in [TABLE_ENTRIES];
   logic [7:0]         nv_mem [NV_BYTES];
   logic [NV_BYTES-1:0] nv_vld_ff, nv_vld_in;
   logic [15:0]        msg_ff, msg_in;
   logic [7:0]         resp_unit_ff, resp_unit_in;
   logic               talk_ff, talk_in;
   logic [7:0]         raddr_ff, raddr_in;
   logic [7:0]         nv_q_ff;
   logic               nv_vq_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic [1:0]         out_relay_ff, out_relay_in;

   logic               rx_abort, out_free;
   logic [7:0]         map_rdata, emit_byte, rmw_data, bit_mask;
   logic [7:0]         waddr, wdata, rd_diff, wr_diff, nv_rdiff;
   logic               nv_we;
   logic [NV_W-1:0]    nv_widx;
   logic [7:0]         nv_wdata;

   assign rx_abort = line_error || gap_ff || (count_ff >= COUNT_W'(FRAME_MAX));
   assign out_free = !out_valid_ff || rsp_ready;
   assign bit_mask = 8'h01 << hdr_ff[3][2:0];
   assign nv_rdiff = raddr_in - ADDR_NV;

   assign status.rx_crc_go = !rx_abort && (count_ff > COUNT_W'(1));
   assign status.frame_ok  = !aborted_ff && (count_ff >= COUNT_W'(2)) &&
                             (hdr_ff[0] == unit_ff || hdr_ff[0] == 8'h00) &&
                             (crc_ff[15:8] == b2_ff) && (crc_ff[7:0] == b1_ff);
   assign status.fn        = hdr_ff[1];
   assign status.len8      = (count_ff == COUNT_W'(8));
   assign status.len4      = (count_ff == COUNT_W'(4));
   assign status.q_ok      = ({hdr_ff[4], hdr_ff[5]} <= 16'(MAX_READ_REGS));
   assign status.q         = hdr_ff[5][Q_W-1:0];
   assign status.out_free  = out_free;

   assign rsp_valid   = out_valid_ff;
   assign tx_byte     = out_byte_ff;
   assign last_byte   = out_last_ff;
   assign relay_state = out_relay_ff;

   // register map read, from the address captured in the read cycle
   always_comb begin
      rd_diff   = 8'h00;
      map_rdata = 8'h00;
      if (raddr_ff == ADDR_RELAY) begin
         map_rdata = {3'b000, relays_ff[1], 3'b000, relays_ff[0]};
      end else if (raddr_ff < ADDR_DEV1) begin
         map_rdata = 8'h00;
      end else if (raddr_ff == ADDR_DEV1) begin
         map_rdata = dev1_ff & DEV_MASK;
      end else if (raddr_ff == ADDR_DEV2) begin
         map_rdata = dev2_ff & DEV_MASK;
      end else if (raddr_ff < ADDR_BLOCK) begin
         rd_diff = raddr_ff - ADDR_PLAN;
         if (rd_diff < 8'(TABLE_ENTRIES)) map_rdata = plan_ff[rd_diff[TABLE_W-1:0]];
      end else if (raddr_ff < ADDR_NV) begin
         rd_diff = raddr_ff - ADDR_BLOCK;
         if (rd_diff < 8'(TABLE_ENTRIES)) map_rdata = block_ff[rd_diff[TABLE_W-1:0]];
      end else if (raddr_ff < ADDR_END) begin
         map_rdata = nv_vq_ff ? nv_q_ff : 8'h00;
      end
   end

   always_comb begin
      rmw_data = map_rdata;
      if (hdr_ff[4] == COIL_ON) rmw_data = rmw_data | bit_mask;
      if (hdr_ff[5] == COIL_ON) rmw_data = rmw_data & ~bit_mask;
   end

   always_comb begin
      case (ctrl.emit_sel)
         E_UNIT:  emit_byte = resp_unit_ff;
         E_MAP:   emit_byte = map_rdata;
         E_BIT:   emit_byte = {7'b0, map_rdata[hdr_ff[3][2:0]]};
         E_FB2:   emit_byte = hdr_ff[2];
         E_FB3:   emit_byte = hdr_ff[3];
         E_FB5:   emit_byte = hdr_ff[5];
         E_MCH:   emit_byte = msg_ff[15:8];
         E_MCL:   emit_byte = msg_ff[7:0];
         E_QX2:   emit_byte = {hdr_ff[5][6:0], 1'b0};
         E_CRCH:  emit_byte = crc_ff[15:8];
         E_CRCL:  emit_byte = crc_ff[7:0];
         default: emit_byte = ctrl.emit_const;
      endcase
   end

   always_comb begin
      hdr_in       = hdr_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      count_in     = count_ff;
      gap_in       = gap_ff;
      aborted_in   = aborted_ff;
      crc_in       = crc_ff;
      unit_in      = unit_ff;
      relays_in    = relays_ff;
      dev1_in      = dev1_ff;
      dev2_in      = dev2_ff;
      plan_in      = plan_ff;
      block_in     = block_ff;
      nv_vld_in    = nv_vld_ff;
      msg_in       = msg_ff;
      resp_unit_in = resp_unit_ff;
      talk_in      = talk_ff;
      raddr_in     = raddr_ff;
      nv_we        = 1'b0;
      nv_widx      = '0;
      nv_wdata     = 8'h00;
      wr_diff      = 8'h00;
      waddr        = ctrl.wr_rmw ? raddr_ff : hdr_ff[3];
      wdata        = ctrl.wr_rmw ? rmw_data : hdr_ff[5];

      if (ctrl.rx_store) begin
         if (rx_abort) begin
            crc_in     = CRC_INIT;
            count_in   = '0;
            aborted_in = 1'b1;
         end else begin
            if (count_ff < COUNT_W'(HDR_BYTES)) hdr_in[count_ff[HDR_W-1:0]] = rx_byte;
            if (count_ff > COUNT_W'(1)) crc_in = crc_step(crc_ff ^ {8'h00, b2_ff});
            b2_in    = b1_ff;
            b1_in    = rx_byte;
            count_in = count_ff + COUNT_W'(1);
         end
      end
      if (ctrl.gap_set) gap_in = 1'b1;
      if (ctrl.clear_rx) begin
         crc_in     = CRC_INIT;
         count_in   = '0;
         gap_in     = 1'b0;
         aborted_in = 1'b0;
      end
      if (ctrl.exec_start) begin
         crc_in       = CRC_INIT;
         resp_unit_in = unit_ff;
         talk_in      = (hdr_ff[0] == unit_ff);
      end
      if (ctrl.msg_inc) msg_in = msg_ff + 16'd1;
      if (ctrl.crc_shift) crc_in = crc_step(crc_ff);
      if (ctrl.emit_crc) crc_in = crc_step(crc_ff ^ {8'h00, emit_byte});
      if (ctrl.rd_en) begin
         raddr_in = ctrl.rd_seq ? (hdr_ff[3] + 8'(ctrl.rd_offset))
                                : {hdr_ff[2][2:0], hdr_ff[3][7:3]};
      end

      if (ctrl.wr_en) begin
         if (waddr == ADDR_UNIT) begin
            unit_in = wdata;
            if (NV_BYTES > 1) begin
               nv_we    = 1'b1;
               nv_widx  = NV_W'(1);
               nv_wdata = wdata;
            end
         end else if (waddr == ADDR_RELAY) begin
            if (wdata[0]) relays_in[0] = 1'b1;
            if (wdata[1]) relays_in[0] = 1'b0;
            if (wdata[2]) relays_in[1] = 1'b1;
            if (wdata[3]) relays_in[1] = 1'b0;
         end else if (waddr < ADDR_DEV1) begin
            relays_in = relays_ff;
         end else if (waddr == ADDR_DEV1) begin
            dev1_in = wdata;
         end else if (waddr == ADDR_DEV2) begin
            dev2_in = wdata;
         end else if (waddr < ADDR_BLOCK) begin
            wr_diff = waddr - ADDR_PLAN;
            if (wr_diff < 8'(TABLE_ENTRIES)) begin
               plan_in[wr_diff[TABLE_W-1:0]] = wdata & block_ff[wr_diff[TABLE_W-1:0]];
            end
         end else if (waddr < ADDR_NV) begin
            wr_diff = waddr - ADDR_BLOCK;
            if (wr_diff < 8'(TABLE_ENTRIES)) begin
               block_in[wr_diff[TABLE_W-1:0]] = wdata;
               plan_in[wr_diff[TABLE_W-1:0]]  = plan_ff[wr_diff[TABLE_W-1:0]] & wdata;
            end
         end else if (waddr < ADDR_END) begin
            wr_diff = waddr - ADDR_NV;
            if (wr_diff < 8'(NV_BYTES)) begin
               nv_we    = 1'b1;
               nv_widx  = wr_diff[NV_W-1:0];
               nv_wdata = wdata;
            end
         end
      end
      if (nv_we) nv_vld_in[nv_widx] = 1'b1;

      if (csr_write) begin
         unique case (csr_index)
            REG_UNIT_ID: unit_in   = csr_wdata;
            REG_RELAYS:  relays_in = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_relay_in = out_relay_ff;
      if (ctrl.emit_en && talk_ff) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = ctrl.emit_last;
         out_relay_in = relays_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (nv_we) nv_mem[nv_widx] <= nv_wdata;
      if (ctrl.rd_en) begin
         nv_q_ff  <= nv_mem[nv_rdiff[NV_W-1:0]];
         nv_vq_ff <= (nv_rdiff < 8'(NV_BYTES)) && nv_vld_ff[nv_rdiff[NV_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      resp_unit_ff <= resp_unit_in;
      raddr_ff     <= raddr_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_relay_ff <= out_relay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gap_ff       <= 1'b0;
         aborted_ff   <= 1'b0;
         crc_ff       <= CRC_INIT;
         unit_ff      <= 8'd1;
         relays_ff    <= 2'd0;
         dev1_ff      <= 8'h00;
         dev2_ff      <= 8'h00;
         plan_ff      <= '{default: 8'h00};
         block_ff     <= '{default: 8'h00};
         nv_vld_ff    <= '0;
         msg_ff       <= 16'h0000;
         talk_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gap_ff       <= gap_in;
         aborted_ff   <= aborted_in;
         crc_ff       <= crc_in;
         unit_ff      <= unit_in;
         relays_ff    <= relays_in;
         dev1_ff      <= dev1_in;
         dev2_ff      <= dev2_in;
         plan_ff      <= plan_in;
         block_ff     <= block_in;
         nv_vld_ff    <= nv_vld_in;
         msg_ff       <= msg_in;
         talk_ff      <= talk_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[design/modbus_rtu_slave_engine.sv]
// top level of the modbus rtu slave engine
// req_ch carries receiver events: a received byte with its line error flag,
// the inter-character gap event and the frame end event. csr_ch writes the
// unit id (index 0) and the relay pair (index 1); it is always ready. The user
// must see that it is written only while the engine is idle; it is not enforced.
// rsp_ch delivers the reply one byte per request, last_byte marks the final crc
// byte, relay_state shows the relays. A received byte past the second runs
// through the serial crc, one bit per cycle, while no new request is taken; the
// first two bytes of a frame, aborted bytes and the other events skip the crc.
// At frame end a valid frame addressed to this unit is executed: a decode step,
// a bit read for functions 1 and 5, a write for functions 5 and 6, then every
// reply byte up to the crc through the same serial crc, with a register map
// read before each register map byte, then the two crc bytes and a closing
// step. Broadcast frames are executed without reply in the same time.
// A single output register holds the current byte; when the receiver stalls the
// engine waits with the next byte and accepts no new request until the reply is
// through. Reset is synchronous: unit id 1, relays off, tables, counters and
// store cleared, receiver empty.
module modbus_rtu_slave_engine import mrs_pkg::*; (
   input logic         clock,
   input logic         reset,
   mrs_req_if.sink     req_ch,
   mrs_rsp_if.source   rsp_ch,
   mrs_csr_if.sink     csr_ch
);

   mrs_ctrl_type   ctrl;
   mrs_status_type status;

   assign csr_ch.ready = 1'b1;

   mrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   mrs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (req_ch.rx_byte),
      .line_error  (req_ch.line_error),
      .csr_write   (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_wdata   (csr_ch.wdata),
      .ctrl        (ctrl),
      .status      (status),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .tx_byte     (rsp_ch.tx_byte),
      .last_byte   (rsp_ch.last_byte),
      .relay_state (rsp_ch.relay_state)
   );

endmodule
